// ===== design/bpor_pkg.sv =====
// ----------------------------------------------------------------------------
// Ball pair overlap resolver package
// Shared constants and the side payload carried down the pipeline.
// ----------------------------------------------------------------------------
package bpor_pkg;

	localparam int FRAC_BITS = 16;

	localparam int POS_W  = 32;
	localparam int RAD_W  = 30;
	localparam int MIND_W = RAD_W + 1;
	localparam int ROOT_W = MIND_W;
	localparam int D2_W   = 2 * MIND_W;
	localparam int NUM_W  = 2 * MIND_W;

	localparam int SQ_STEPS  = ROOT_W;
	localparam int DIV_STEPS = MIND_W;

	localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(327680);

	// 0.1 in 2*FRAC_BITS fraction bits, floored
	localparam logic [D2_W:0] TENTH = (D2_W+1)'((64'd1 << (2 * FRAC_BITS)) / 10);
	// 0.01 in FRAC_BITS fraction bits, rounded
	localparam logic [MIND_W-1:0] OFFSET =
		MIND_W'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);

	typedef struct packed {
		logic [POS_W-1:0]  ax;
		logic [POS_W-1:0]  ay;
		logic [POS_W-1:0]  bx;
		logic [POS_W-1:0]  by;
		logic [MIND_W-1:0] ux;
		logic [MIND_W-1:0] uy;
		logic              sx;
		logic              sy;
		logic              hit;
	} side_t;

endpackage

// ===== design/ball_pair_overlap_resolver.sv =====
// ----------------------------------------------------------------------------
// Ball pair overlap resolver
// Pushes two overlapping equal-radius balls apart along their normal.
// ----------------------------------------------------------------------------
// Pairs pass s1-s5, the square root, s6-s8, the divider and a done register.
// Throughput: one pair per cycle; busy never rises, the pipeline is fully
// feed-forward and each result is shown for one cycle on done.
// Depth is set by the square root (one root bit per stage) and the two-lane
// divider (one quotient bit per stage).
// Reset clears all valid bits and sets the radius to 5.0.
module ball_pair_overlap_resolver import bpor_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [POS_W-1:0] first_x,
	input  logic signed [POS_W-1:0] first_y,
	input  logic signed [POS_W-1:0] second_x,
	input  logic signed [POS_W-1:0] second_y,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic        [RAD_W-1:0] ball_radius,
	output logic                    done,
	output logic signed [POS_W-1:0] new_first_x,
	output logic signed [POS_W-1:0] new_first_y,
	output logic signed [POS_W-1:0] new_second_x,
	output logic signed [POS_W-1:0] new_second_y,
	output logic                    pushed
);

	function automatic logic [POS_W-1:0] sat_pos(input logic signed [POS_W+1:0] v);
		logic signed [POS_W+1:0] hi;
		logic signed [POS_W+1:0] lo;
		hi = (POS_W+2)'({1'b0, {(POS_W-1){1'b1}}});
		lo = -(POS_W+2)'({1'b1, {(POS_W-1){1'b0}}});
		if (v > hi) begin
			return {1'b0, {(POS_W-1){1'b1}}};
		end else if (v < lo) begin
			return {1'b1, {(POS_W-1){1'b0}}};
		end else begin
			return v[POS_W-1:0];
		end
	endfunction

	function automatic logic signed [POS_W+1:0] ext_pos(input logic [POS_W-1:0] v);
		return signed'({{2{v[POS_W-1]}}, v});
	endfunction

	function automatic logic signed [POS_W+1:0] ext_quo(input logic [MIND_W-1:0] v);
		return signed'({{(POS_W+2-MIND_W){1'b0}}, v});
	endfunction

	// configuration
	logic [RAD_W-1:0]  radius_q;
	logic [D2_W-1:0]   min_sq_q;
	logic [MIND_W-1:0] min_d;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;
	assign min_d     = {radius_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			radius_q <= ball_radius;
		end
	end

	always_ff @(posedge clk) begin
		min_sq_q <= D2_W'(min_d) * D2_W'(min_d);
	end

	// s1: differences
	logic             vld_s1;
	logic [POS_W-1:0] ax_s1, ay_s1, bx_s1, by_s1;
	logic [POS_W:0]   dx_s1, dy_s1;

	// s2: magnitudes and box test
	logic              vld_s2;
	side_t             side_s2;

	// s3: squares
	logic              vld_s3;
	side_t             side_s3;
	logic [D2_W-1:0]   sqx_s3, sqy_s3;

	// s4: squared distance
	logic              vld_s4;
	side_t             side_s4;
	logic [D2_W:0]     d2_s4;

	// s5: overlap test
	logic              vld_s5;
	side_t             side_s5;
	logic [D2_W-1:0]   d2_s5;

	logic [POS_W:0]    ux_w, uy_w;
	logic              hit_w;
	side_t             side_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_comb begin
		ux_w       = dx_s1[POS_W] ? (POS_W+1)'(-dx_s1) : dx_s1;
		uy_w       = dy_s1[POS_W] ? (POS_W+1)'(-dy_s1) : dy_s1;
		hit_w      = (d2_s4 < {1'b0, min_sq_q}) && (d2_s4 > TENTH) && side_s4.hit;
		side_w     = side_s4;
		side_w.hit = hit_w;
	end

	always_ff @(posedge clk) begin
		ax_s1 <= first_x;
		ay_s1 <= first_y;
		bx_s1 <= second_x;
		by_s1 <= second_y;
		dx_s1 <= {second_x[POS_W-1], second_x} - {first_x[POS_W-1], first_x};
		dy_s1 <= {second_y[POS_W-1], second_y} - {first_y[POS_W-1], first_y};

		side_s2.ax  <= ax_s1;
		side_s2.ay  <= ay_s1;
		side_s2.bx  <= bx_s1;
		side_s2.by  <= by_s1;
		side_s2.ux  <= ux_w[MIND_W-1:0];
		side_s2.uy  <= uy_w[MIND_W-1:0];
		side_s2.sx  <= dx_s1[POS_W];
		side_s2.sy  <= dy_s1[POS_W];
		side_s2.hit <= (ux_w < (POS_W+1)'(min_d)) && (uy_w < (POS_W+1)'(min_d));

		side_s3 <= side_s2;
		sqx_s3  <= D2_W'(side_s2.ux) * D2_W'(side_s2.ux);
		sqy_s3  <= D2_W'(side_s2.uy) * D2_W'(side_s2.uy);

		side_s4 <= side_s3;
		d2_s4   <= {1'b0, sqx_s3} + {1'b0, sqy_s3};

		side_s5 <= side_w;
		d2_s5   <= d2_s4[D2_W-1:0];
	end

	// square root
	logic              vld_rt;
	logic [ROOT_W-1:0] dist_rt;
	side_t             side_rt;

	bpor_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s5),
		.in_rad   (d2_s5),
		.in_side  (side_s5),
		.out_vld  (vld_rt),
		.out_root (dist_rt),
		.out_side (side_rt)
	);

	// s6: push magnitude, s7: products, s8: rounding bias
	logic              vld_s6, vld_s7, vld_s8;
	side_t             side_s6, side_s7, side_s8;
	logic [MIND_W-1:0] dist_s6, dist_s7, dist_s8;
	logic [MIND_W-1:0] mag_s6;
	logic [NUM_W-1:0]  px_s7, py_s7;
	logic [NUM_W-1:0]  nx_s8, ny_s8;
	logic [MIND_W-1:0] gap_w;

	assign gap_w = min_d - dist_rt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s6 <= vld_rt;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		side_s6 <= side_rt;
		dist_s6 <= dist_rt;
		mag_s6  <= (gap_w >> 1) + OFFSET;

		side_s7 <= side_s6;
		dist_s7 <= dist_s6;
		px_s7   <= NUM_W'(side_s6.ux) * NUM_W'(mag_s6);
		py_s7   <= NUM_W'(side_s6.uy) * NUM_W'(mag_s6);

		side_s8 <= side_s7;
		dist_s8 <= dist_s7;
		nx_s8   <= px_s7 + NUM_W'(dist_s7 >> 1);
		ny_s8   <= py_s7 + NUM_W'(dist_s7 >> 1);
	end

	// division by distance
	logic              vld_dv;
	logic [MIND_W-1:0] qx_dv, qy_dv;
	side_t             side_dv;

	bpor_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (vld_s8),
		.in_num_x  (nx_s8),
		.in_num_y  (ny_s8),
		.in_den    (dist_s8),
		.in_side   (side_s8),
		.out_vld   (vld_dv),
		.out_quo_x (qx_dv),
		.out_quo_y (qy_dv),
		.out_side  (side_dv)
	);

	// apply push and saturate
	logic signed [POS_W+1:0] fx_w, fy_w, sx_w, sy_w;
	logic                    done_q, pushed_q;
	logic [POS_W-1:0]        nfx_q, nfy_q, nsx_q, nsy_q;

	always_comb begin
		fx_w = ext_pos(side_dv.ax);
		fy_w = ext_pos(side_dv.ay);
		sx_w = ext_pos(side_dv.bx);
		sy_w = ext_pos(side_dv.by);
		if (side_dv.hit) begin
			if (side_dv.sx) begin
				fx_w = fx_w + ext_quo(qx_dv);
				sx_w = sx_w - ext_quo(qx_dv);
			end else begin
				fx_w = fx_w - ext_quo(qx_dv);
				sx_w = sx_w + ext_quo(qx_dv);
			end
			if (side_dv.sy) begin
				fy_w = fy_w + ext_quo(qy_dv);
				sy_w = sy_w - ext_quo(qy_dv);
			end else begin
				fy_w = fy_w - ext_quo(qy_dv);
				sy_w = sy_w + ext_quo(qy_dv);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_dv;
		end
	end

	always_ff @(posedge clk) begin
		nfx_q    <= sat_pos(fx_w);
		nfy_q    <= sat_pos(fy_w);
		nsx_q    <= sat_pos(sx_w);
		nsy_q    <= sat_pos(sy_w);
		pushed_q <= side_dv.hit;
	end

	assign done         = done_q;
	assign new_first_x  = signed'(nfx_q);
	assign new_first_y  = signed'(nfy_q);
	assign new_second_x = signed'(nsx_q);
	assign new_second_y = signed'(nsy_q);
	assign pushed       = pushed_q;

endmodule

// ===== design/bpor_sqrt.sv =====
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per stage, floor result, side payload travels alongside.
// ----------------------------------------------------------------------------
module bpor_sqrt import bpor_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [D2_W-1:0]   in_rad,
	input  side_t             in_side,
	output logic              out_vld,
	output logic [ROOT_W-1:0] out_root,
	output side_t             out_side
);

	logic              vld_s  [0:SQ_STEPS];
	logic [ROOT_W:0]   rem_s  [0:SQ_STEPS];
	logic [ROOT_W-1:0] root_s [0:SQ_STEPS];
	logic [D2_W-1:0]   rad_s  [0:SQ_STEPS];
	side_t             side_s [0:SQ_STEPS];

	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = in_rad;
	assign side_s[0] = in_side;

	genvar k;
	for (k = 0; k < SQ_STEPS; k++) begin : g_step
		logic [ROOT_W+2:0] t_w;
		logic [ROOT_W+2:0] trial_w;
		logic [ROOT_W+2:0] diff_w;
		logic              ge_w;

		always_comb begin
			t_w     = {rem_s[k], rad_s[k][D2_W-1:D2_W-2]};
			trial_w = {1'b0, root_s[k], 2'b01};
			diff_w  = t_w - trial_w;
			ge_w    = (t_w >= trial_w);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge_w ? diff_w[ROOT_W:0] : t_w[ROOT_W:0];
			root_s[k+1] <= {root_s[k][ROOT_W-2:0], ge_w};
			rad_s[k+1]  <= {rad_s[k][D2_W-3:0], 2'b00};
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_vld  = vld_s[SQ_STEPS];
	assign out_root = root_s[SQ_STEPS];
	assign out_side = side_s[SQ_STEPS];

endmodule

// ===== design/bpor_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined dual-lane divider
// Restoring division, one quotient bit per stage for both lanes.
// Quotient is known to fit MIND_W bits.
// ----------------------------------------------------------------------------
module bpor_div import bpor_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [NUM_W-1:0]  in_num_x,
	input  logic [NUM_W-1:0]  in_num_y,
	input  logic [MIND_W-1:0] in_den,
	input  side_t             in_side,
	output logic              out_vld,
	output logic [MIND_W-1:0] out_quo_x,
	output logic [MIND_W-1:0] out_quo_y,
	output side_t             out_side
);

	logic              vld_s  [0:DIV_STEPS];
	logic [MIND_W-1:0] rx_s   [0:DIV_STEPS];
	logic [MIND_W-1:0] lx_s   [0:DIV_STEPS];
	logic [MIND_W-1:0] ry_s   [0:DIV_STEPS];
	logic [MIND_W-1:0] ly_s   [0:DIV_STEPS];
	logic [MIND_W-1:0] den_s  [0:DIV_STEPS];
	side_t             side_s [0:DIV_STEPS];

	assign vld_s[0]  = in_vld;
	assign rx_s[0]   = in_num_x[NUM_W-1:MIND_W];
	assign lx_s[0]   = in_num_x[MIND_W-1:0];
	assign ry_s[0]   = in_num_y[NUM_W-1:MIND_W];
	assign ly_s[0]   = in_num_y[MIND_W-1:0];
	assign den_s[0]  = in_den;
	assign side_s[0] = in_side;

	genvar k;
	for (k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [MIND_W:0] tx_w;
		logic [MIND_W:0] ty_w;
		logic [MIND_W:0] dx_w;
		logic [MIND_W:0] dy_w;
		logic            gex_w;
		logic            gey_w;

		always_comb begin
			tx_w  = {rx_s[k], lx_s[k][MIND_W-1]};
			ty_w  = {ry_s[k], ly_s[k][MIND_W-1]};
			dx_w  = tx_w - {1'b0, den_s[k]};
			dy_w  = ty_w - {1'b0, den_s[k]};
			gex_w = (tx_w >= {1'b0, den_s[k]});
			gey_w = (ty_w >= {1'b0, den_s[k]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rx_s[k+1]   <= gex_w ? dx_w[MIND_W-1:0] : tx_w[MIND_W-1:0];
			ry_s[k+1]   <= gey_w ? dy_w[MIND_W-1:0] : ty_w[MIND_W-1:0];
			lx_s[k+1]   <= {lx_s[k][MIND_W-2:0], gex_w};
			ly_s[k+1]   <= {ly_s[k][MIND_W-2:0], gey_w};
			den_s[k+1]  <= den_s[k];
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_vld   = vld_s[DIV_STEPS];
	assign out_quo_x = lx_s[DIV_STEPS];
	assign out_quo_y = ly_s[DIV_STEPS];
	assign out_side  = side_s[DIV_STEPS];

endmodule

// ===== tb/bpor_checker.sv =====
// ----------------------------------------------------------------------------
// Ball pair overlap resolver checker
// Watches the pair, result and radius channels, works out the corrected
// positions of every pair taken in and compares each result against them.
// ----------------------------------------------------------------------------
module bpor_checker import bpor_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    busy,
	input  logic signed [POS_W-1:0] first_x,
	input  logic signed [POS_W-1:0] first_y,
	input  logic signed [POS_W-1:0] second_x,
	input  logic signed [POS_W-1:0] second_y,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic        [RAD_W-1:0] ball_radius,
	input  logic                    done,
	input  logic signed [POS_W-1:0] new_first_x,
	input  logic signed [POS_W-1:0] new_first_y,
	input  logic signed [POS_W-1:0] new_second_x,
	input  logic signed [POS_W-1:0] new_second_y,
	input  logic                    pushed,
	output int                      fault_count,
	output int                      in_flight
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] TENTH_SQ   = (64'd1 << (2 * FRAC_BITS)) / 64'd10;
	localparam logic [63:0] NUDGE      = ((64'd1 << FRAC_BITS) + 64'd50) / 64'd100;
	localparam longint      POS_HIGH   = 64'sd2147483647;
	localparam longint      POS_LOW    = -64'sd2147483648;

	typedef struct packed {
		logic [POS_W-1:0] fx;
		logic [POS_W-1:0] fy;
		logic [POS_W-1:0] sx;
		logic [POS_W-1:0] sy;
		logic             hit;
	} corrected_pair_t;

	logic [RAD_W-1:0] radius_q = RADIUS_RESET;
	corrected_pair_t  corrected_q [$];
	int               faults  = 0;
	int               waiting = 0;

	assign fault_count = faults;
	assign in_flight   = waiting;

	function automatic logic [63:0] floor_sqrt(logic [63:0] n);
		logic [63:0] root;
		logic [63:0] probe;
		root  = '0;
		probe = 64'd1 << 62;
		while (probe > n)
			probe >>= 2;
		while (probe != 0) begin
			if (n >= root + probe) begin
				n    -= root + probe;
				root  = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		return root;
	endfunction

	// |d| * mag / norm, rounded half away from zero, sign of d
	function automatic longint push_component(longint d, logic [63:0] mag, logic [63:0] norm);
		logic [63:0] span;
		logic [63:0] q;
		span = (d < 0) ? 64'(-d) : 64'(d);
		q    = (span * mag + (norm >> 1)) / norm;
		return (d < 0) ? -$signed(q) : $signed(q);
	endfunction

	function automatic logic [POS_W-1:0] clamp_pos(longint v);
		if (v > POS_HIGH)
			v = POS_HIGH;
		if (v < POS_LOW)
			v = POS_LOW;
		return v[POS_W-1:0];
	endfunction

	function automatic corrected_pair_t resolve_pair(
		logic signed [POS_W-1:0] ax_in, logic signed [POS_W-1:0] ay_in,
		logic signed [POS_W-1:0] bx_in, logic signed [POS_W-1:0] by_in,
		logic [RAD_W-1:0] radius
	);
		longint          ax, ay, bx, by, dx, dy, px, py;
		logic [63:0]     min_d, ux, uy, d2, norm, mag;
		corrected_pair_t res;
		ax    = ax_in;
		ay    = ay_in;
		bx    = bx_in;
		by    = by_in;
		dx    = bx - ax;
		dy    = by - ay;
		min_d = 64'(radius) << 1;
		ux    = (dx < 0) ? 64'(-dx) : 64'(dx);
		uy    = (dy < 0) ? 64'(-dy) : 64'(dy);
		res.hit = 1'b0;
		// box test first keeps d2 within 64 bits
		if (ux < min_d && uy < min_d) begin
			d2 = ux * ux + uy * uy;
			if (d2 < min_d * min_d && d2 > TENTH_SQ) begin
				norm = floor_sqrt(d2);
				mag  = ((min_d - norm) >> 1) + NUDGE;
				px   = push_component(dx, mag, norm);
				py   = push_component(dy, mag, norm);
				ax  -= px;
				ay  -= py;
				bx  += px;
				by  += py;
				res.hit = 1'b1;
			end
		end
		res.fx = clamp_pos(ax);
		res.fy = clamp_pos(ay);
		res.sx = clamp_pos(bx);
		res.sy = clamp_pos(by);
		return res;
	endfunction

	task automatic check_field(input string name, input logic [POS_W-1:0] want,
			input logic [POS_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
			faults++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			radius_q <= RADIUS_RESET;
		else if (cfg_valid && cfg_ready)
			radius_q <= ball_radius;
	end

	always @(posedge clk) begin
		corrected_pair_t want;
		if (arst_n) begin
			if (done) begin
				if (corrected_q.size() == 0) begin
					$error("result transfer with no pair outstanding");
					faults++;
				end else begin
					want = corrected_q.pop_front();
					check_field("new_first_x", want.fx, new_first_x);
					check_field("new_first_y", want.fy, new_first_y);
					check_field("new_second_x", want.sx, new_second_x);
					check_field("new_second_y", want.sy, new_second_y);
					check_field("pushed", POS_W'(want.hit), POS_W'(pushed));
				end
			end
			if (start && !busy)
				corrected_q.push_back(resolve_pair(first_x, first_y, second_x, second_y,
					radius_q));
			waiting <= corrected_q.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Ball pair overlap resolver testbench
// Drives directed and random ball pairs through several radius settings and
// sender idling patterns; the checker beside the block judges every result.
// ----------------------------------------------------------------------------
module tb import bpor_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          WATCHDOG_LIMIT  = 2000;
	localparam int          DRAIN_CYCLES    = 80;
	localparam int          ITEMS_PER_PHASE = 134;
	localparam int          PHASES          = 6;
	localparam longint      POS_HIGH        = 64'sd2147483647;
	localparam longint      POS_LOW         = -64'sd2147483648;
	localparam logic [31:0] P_MAX           = 32'h7FFF_FFFF;
	localparam logic [31:0] P_MIN           = 32'h8000_0000;

	logic                    clk          = 1'b0;
	logic                    arst_n       = 1'b0;
	logic                    start        = 1'b0;
	logic                    busy;
	logic signed [POS_W-1:0] first_x      = '0;
	logic signed [POS_W-1:0] first_y      = '0;
	logic signed [POS_W-1:0] second_x     = '0;
	logic signed [POS_W-1:0] second_y     = '0;
	logic                    cfg_valid    = 1'b0;
	logic                    cfg_ready;
	logic        [RAD_W-1:0] ball_radius  = RADIUS_RESET;
	logic                    done;
	logic signed [POS_W-1:0] new_first_x;
	logic signed [POS_W-1:0] new_first_y;
	logic signed [POS_W-1:0] new_second_x;
	logic signed [POS_W-1:0] new_second_y;
	logic                    pushed;

	int                      fault_count;
	int                      in_flight;
	int                      quiet_cycles = 0;
	int                      idle_pct     = 0;
	logic        [RAD_W-1:0] radius_now   = RADIUS_RESET;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	ball_pair_overlap_resolver dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.first_x      (first_x),
		.first_y      (first_y),
		.second_x     (second_x),
		.second_y     (second_y),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.ball_radius  (ball_radius),
		.done         (done),
		.new_first_x  (new_first_x),
		.new_first_y  (new_first_y),
		.new_second_x (new_second_x),
		.new_second_y (new_second_y),
		.pushed       (pushed)
	);

	bpor_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.first_x      (first_x),
		.first_y      (first_y),
		.second_x     (second_x),
		.second_y     (second_y),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.ball_radius  (ball_radius),
		.done         (done),
		.new_first_x  (new_first_x),
		.new_first_y  (new_first_y),
		.new_second_x (new_second_x),
		.new_second_y (new_second_y),
		.pushed       (pushed),
		.fault_count  (fault_count),
		.in_flight    (in_flight)
	);

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic pause_sender();
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
	endtask

	task automatic send_pair(input logic [POS_W-1:0] ax, ay, bx, by);
		start    <= 1'b1;
		first_x  <= ax;
		first_y  <= ay;
		second_x <= bx;
		second_y <= by;
		do
			@(posedge clk);
		while (busy);
		pause_sender();
	endtask

	// radius changes only once every pair in flight has come back
	task automatic set_radius(input logic [RAD_W-1:0] r);
		start <= 1'b0;
		@(posedge clk);
		while (in_flight != 0)
			@(posedge clk);
		cfg_valid   <= 1'b1;
		ball_radius <= r;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid  <= 1'b0;
		radius_now  = r;
	endtask

	function automatic longint pick_offset(longint span);
		longint mag;
		int     kind;
		kind = $urandom_range(9);
		if (kind < 6)
			mag = $urandom_range(32'(span - 1), 0);
		else if (kind < 8)
			mag = $urandom_range(2000, 0);
		else
			mag = span - 2 + $urandom_range(3, 0);
		return $urandom_range(1) ? -mag : mag;
	endfunction

	function automatic logic [POS_W-1:0] place(longint base, longint off);
		longint pos;
		pos = base + off;
		if (pos > POS_HIGH || pos < POS_LOW)
			pos = base - off;
		return pos[POS_W-1:0];
	endfunction

	function automatic longint pick_base(bit near_rail);
		int raw;
		raw = $urandom();
		if (!near_rail)
			return raw;
		return $urandom_range(1) ? POS_HIGH - $urandom_range(1000) :
			POS_LOW + $urandom_range(1000);
	endfunction

	// mostly overlapping or grazing pairs, some rail hugging, some noise
	task automatic make_pair(output logic [POS_W-1:0] ax, ay, bx, by);
		longint span, base_x, base_y;
		int     sel;
		span = 2 * longint'(radius_now);
		sel  = $urandom_range(99);
		if (sel < 15) begin
			ax = $urandom();
			ay = $urandom();
			bx = $urandom();
			by = $urandom();
		end else begin
			base_x = pick_base(sel >= 85);
			base_y = pick_base(sel >= 85 && $urandom_range(1));
			ax = base_x[POS_W-1:0];
			ay = base_y[POS_W-1:0];
			bx = place(base_x, pick_offset(span));
			by = place(base_y, pick_offset(span));
		end
	endtask

	initial begin
		logic [RAD_W-1:0] radius_plan [PHASES];
		logic [POS_W-1:0] ax, ay, bx, by;
		radius_plan = '{RADIUS_RESET, RAD_W'(1), {RAD_W{1'b1}},
			RAD_W'($urandom_range(32'h40_0000, 32'h1_0000)),
			RAD_W'($urandom_range(32'h3FFF_FFFF, 32'h100_0000)), RAD_W'(655)};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// radius 5.0 out of reset: contact distance 655360
		send_pair(0, 0, 0, 0);
		send_pair(0, 0, 1, 0);
		send_pair(0, 0, 655, 0);
		send_pair(0, 0, 656, 0);
		send_pair(0, 0, 655359, 0);
		send_pair(0, 0, 655360, 0);
		send_pair(0, 0, -655360, 0);
		send_pair(0, 0, 500000, 500000);
		send_pair(0, 0, -300000, 200000);
		send_pair(1000, 1000, 1000, 301000);
		send_pair(12345, -54321, 12345 - 200000, -54321 - 100000);
		send_pair(P_MAX, 0, P_MAX - 100000, 0);
		send_pair(P_MIN, 0, P_MIN + 100000, 0);
		send_pair(0, P_MAX - 100000, 0, P_MAX);
		send_pair(0, P_MIN + 100000, 0, P_MIN);
		send_pair(P_MIN, P_MIN, P_MAX, P_MAX);
		send_pair(P_MAX, P_MAX, P_MIN, P_MIN);
		send_pair(-1, -1, -1, -1);
		send_pair(P_MAX - 200, P_MIN + 300, P_MAX - 900, P_MIN + 100);

		for (int ph = 0; ph < PHASES; ph++) begin
			idle_pct = (ph < 2) ? 7 : (ph < 4) ? 82 : 0;
			set_radius(radius_plan[ph]);
			repeat (ITEMS_PER_PHASE) begin
				make_pair(ax, ay, bx, by);
				send_pair(ax, ay, bx, by);
			end
		end

		start <= 1'b0;
		@(posedge clk);
		while (in_flight != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0 && in_flight == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
design/bpor_pkg.sv
design/bpor_sqrt.sv
design/bpor_div.sv
design/ball_pair_overlap_resolver.sv
tb/bpor_checker.sv
tb/tb.sv
